/* hdl/tlik_pkg.sv */
// shared widths, register codes, reset values and the arctangent table
// for the two-link planar inverse kinematics servo block
// no dependencies
package tlik_pkg;

  // payload field widths
  localparam int X_W      = 14;
  localparam int LINK_W   = 12;
  localparam int DEG_W    = 9;
  localparam int PULSE_W  = 12;
  localparam int STEP_W   = 5;

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 12;

  // internal datapath widths
  localparam int XX_W    = 27;  // x squared
  localparam int LSQ_W   = 24;  // link squared or link product
  localparam int SUM2_W  = 26;  // (l1 + l2) squared
  localparam int DIF2_W  = 24;  // (l1 - l2) squared
  localparam int D2_W    = 28;  // x^2 + z^2
  localparam int P_W     = 25;  // 2 l1 l2
  localparam int N_W     = 26;  // d^2 - l1^2 - l2^2, signed
  localparam int W_W     = 30;  // 2 l1^2 + n, signed
  localparam int RAD_W   = 50;  // radicand p^2 - n^2
  localparam int ROOT_W  = RAD_W / 2;
  localparam int ISQ_STEPS = RAD_W / 2;

  // vectoring rotator
  localparam int VIN_W       = 31;
  localparam int CW          = 33;
  localparam int M_W         = 32;
  localparam int ANG_W       = 32;
  localparam int ANG_FRAC    = 20;
  localparam int NORM_SHIFTS = 5;
  localparam int NORM_TOP    = 30;
  localparam int CORDIC_MAX  = 24;
  localparam int CORDIC_DEF  = 16;

  localparam logic signed [ANG_W-1:0] ANG_90 = 32'sd94371840;

  // atan(2^-i) in units of 2^-20 degree
  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7
  };

  // servo pulse limits
  localparam logic signed [15:0] PULSE_LOW  = 16'sd500;
  localparam logic signed [15:0] PULSE_HIGH = 16'sd2500;

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_LINK1    = 3'd0,
    CFG_LINK2    = 3'd1,
    CFG_S_MIN    = 3'd2,
    CFG_S_MAX    = 3'd3,
    CFG_E_MIN    = 3'd4,
    CFG_E_MAX    = 3'd5,
    CFG_P_CENTER = 3'd6,
    CFG_P_STEP   = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [LINK_W-1:0]        RST_LINK1    = 12'd3507;
  localparam logic [LINK_W-1:0]        RST_LINK2    = 12'd2560;
  localparam logic signed [DEG_W-1:0]  RST_DEG_MIN  = -9'sd90;
  localparam logic signed [DEG_W-1:0]  RST_DEG_MAX  = 9'sd90;
  localparam logic [PULSE_W-1:0]       RST_P_CENTER = 12'd1500;
  localparam logic [STEP_W-1:0]        RST_P_STEP   = 5'd10;

  // limits and pulse mapping handed to the output stage
  typedef struct packed {
    logic signed [DEG_W-1:0] s_min;
    logic signed [DEG_W-1:0] s_max;
    logic signed [DEG_W-1:0] e_min;
    logic signed [DEG_W-1:0] e_max;
    logic [PULSE_W-1:0]      center;
    logic [STEP_W-1:0]       step;
  } post_cfg_t;

  // one result transaction
  typedef struct packed {
    logic                    reachable;
    logic signed [DEG_W-1:0] shoulder_deg;
    logic signed [DEG_W-1:0] elbow_angle;
    logic [PULSE_W-1:0]      shoulder_pulse;
    logic [PULSE_W-1:0]      elbow_pulse;
  } result_t;

endpackage

/* hdl/tlik_delay.sv */
// shift line that carries side data alongside a pipelined unit
// no package dependencies
module tlik_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // advance all taps together
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

/* hdl/tlik_isqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on tlik_pkg for the radicand width
module tlik_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [tlik_pkg::RAD_W-1:0]   in_rad,
  output logic                         out_v,
  output logic [tlik_pkg::ROOT_W-1:0]  out_root
);
  import tlik_pkg::*;

  logic [RAD_W:0] rem_r  [ISQ_STEPS];
  logic [RAD_W:0] root_r [ISQ_STEPS];
  logic           v_r    [ISQ_STEPS];

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ISQ_STEPS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < ISQ_STEPS; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // one restoring step per stage, trial bit from the top pair down
  for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_step
    localparam logic [RAD_W:0] BIT = {{RAD_W{1'b0}}, 1'b1} << (RAD_W - 2 - 2 * i);
    logic [RAD_W:0] rem_in, root_in, trial;
    logic [RAD_W:0] rem_nxt, root_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = {1'b0, in_rad};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    always_comb begin
      trial = root_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
      end
    end
  end

  assign out_v    = v_r[ISQ_STEPS-1];
  assign out_root = root_r[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

/* hdl/tlik_cordic.sv */
// pipelined vectoring rotator giving atan2(y, x) in 2^-20 degree units:
// quadrant fold, five-stage normalizing shift, one micro-rotation per stage
// depends on tlik_pkg for widths and the arctangent table
module tlik_cordic #(
  parameter int ITER = tlik_pkg::CORDIC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic signed [tlik_pkg::VIN_W-1:0] in_y,
  input  logic signed [tlik_pkg::VIN_W-1:0] in_x,
  output logic                              out_v,
  output logic signed [tlik_pkg::ANG_W-1:0] out_ang
);
  import tlik_pkg::*;

  localparam int LAT = 1 + NORM_SHIFTS + ITER;

  logic v_r [LAT];

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < LAT; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // quadrant fold so that x is not negative
  logic signed [CW-1:0]    ex, ey, x0_nxt, y0_nxt, ay;
  logic signed [ANG_W-1:0] a0_nxt;
  logic [M_W-1:0]          m0_nxt;
  logic                    z0_nxt;
  logic signed [CW-1:0]    pre_x_r, pre_y_r;
  logic signed [ANG_W-1:0] pre_a_r;
  logic [M_W-1:0]          pre_m_r;
  logic                    pre_z_r;

  always_comb begin
    ex     = CW'(in_x);
    ey     = CW'(in_y);
    z0_nxt = (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_nxt = ey;
        y0_nxt = -ex;
        a0_nxt = ANG_90;
      end else begin
        x0_nxt = -ey;
        y0_nxt = ex;
        a0_nxt = -ANG_90;
      end
    end else begin
      x0_nxt = ex;
      y0_nxt = ey;
      a0_nxt = '0;
    end
    ay     = (y0_nxt < 0) ? -y0_nxt : y0_nxt;
    m0_nxt = (x0_nxt > ay) ? x0_nxt[M_W-1:0] : ay[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_x_r <= x0_nxt;
      pre_y_r <= y0_nxt;
      pre_a_r <= a0_nxt;
      pre_m_r <= m0_nxt;
      pre_z_r <= z0_nxt;
    end
  end

  // normalizing shift, shifts of 16, 8, 4, 2, 1
  logic signed [CW-1:0]    nx_r [NORM_SHIFTS];
  logic signed [CW-1:0]    ny_r [NORM_SHIFTS];
  logic signed [ANG_W-1:0] na_r [NORM_SHIFTS];
  logic [M_W-1:0]          nm_r [NORM_SHIFTS];
  logic                    nz_r [NORM_SHIFTS];

  for (genvar j = 0; j < NORM_SHIFTS; j++) begin : g_norm
    localparam int K = 1 << (NORM_SHIFTS - 1 - j);
    localparam logic [M_W-1:0] TH = {{(M_W-1){1'b0}}, 1'b1} << (NORM_TOP - K);
    logic signed [CW-1:0]    x_in, y_in;
    logic signed [ANG_W-1:0] a_in;
    logic [M_W-1:0]          m_in;
    logic                    z_in;

    if (j == 0) begin : g_first
      assign x_in = pre_x_r;
      assign y_in = pre_y_r;
      assign a_in = pre_a_r;
      assign m_in = pre_m_r;
      assign z_in = pre_z_r;
    end else begin : g_next
      assign x_in = nx_r[j-1];
      assign y_in = ny_r[j-1];
      assign a_in = na_r[j-1];
      assign m_in = nm_r[j-1];
      assign z_in = nz_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (m_in < TH) begin
          nx_r[j] <= x_in <<< K;
          ny_r[j] <= y_in <<< K;
          nm_r[j] <= m_in << K;
        end else begin
          nx_r[j] <= x_in;
          ny_r[j] <= y_in;
          nm_r[j] <= m_in;
        end
        na_r[j] <= a_in;
        nz_r[j] <= z_in;
      end
    end
  end

  // micro-rotations driving y toward zero
  logic signed [CW-1:0]    ix_r [ITER];
  logic signed [CW-1:0]    iy_r [ITER];
  logic signed [ANG_W-1:0] ia_r [ITER];
  logic                    iz_r [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    logic signed [CW-1:0]    x_in, y_in, dx, dy;
    logic signed [ANG_W-1:0] a_in;
    logic                    z_in;

    if (i == 0) begin : g_first
      assign x_in = nx_r[NORM_SHIFTS-1];
      assign y_in = ny_r[NORM_SHIFTS-1];
      assign a_in = na_r[NORM_SHIFTS-1];
      assign z_in = nz_r[NORM_SHIFTS-1];
    end else begin : g_next
      assign x_in = ix_r[i-1];
      assign y_in = iy_r[i-1];
      assign a_in = ia_r[i-1];
      assign z_in = iz_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_in > 0) begin
          ix_r[i] <= x_in + dx;
          iy_r[i] <= y_in - dy;
          ia_r[i] <= a_in + ATAN_TAB[i];
        end else begin
          ix_r[i] <= x_in - dx;
          iy_r[i] <= y_in + dy;
          ia_r[i] <= a_in - ATAN_TAB[i];
        end
        iz_r[i] <= z_in;
      end
    end
  end

  // zero vector reads as zero degrees
  assign out_v   = v_r[LAT-1];
  assign out_ang = iz_r[ITER-1] ? '0 : ia_r[ITER-1];

endmodule

/* hdl/tlik_post.sv */
// output stages: shoulder difference, degree clamp, truncation to whole
// degrees, pulse mapping and pulse clamp; depends on tlik_pkg
module tlik_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic                              in_reach,
  input  logic signed [tlik_pkg::ANG_W-1:0] a_target,
  input  logic signed [tlik_pkg::ANG_W-1:0] a_elbow,
  input  logic signed [tlik_pkg::ANG_W-1:0] a_offset,
  input  tlik_pkg::post_cfg_t               cfg,
  output logic                              out_v,
  output tlik_pkg::result_t                 out_res
);
  import tlik_pkg::*;

  localparam int PW = 16;

  function automatic logic signed [ANG_W-1:0] clamp_ang(
    input logic signed [ANG_W-1:0] a,
    input logic signed [DEG_W-1:0] lo,
    input logic signed [DEG_W-1:0] hi
  );
    logic signed [ANG_W-1:0] lo_a, hi_a, c;
    lo_a = ANG_W'(lo) <<< ANG_FRAC;
    hi_a = ANG_W'(hi) <<< ANG_FRAC;
    c = (a < lo_a) ? lo_a : a;
    c = (c > hi_a) ? hi_a : c;
    return c;
  endfunction

  function automatic logic signed [DEG_W-1:0] trunc_deg(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    t = (a >= 0) ? (a >>> ANG_FRAC) : -((-a) >>> ANG_FRAC);
    return t[DEG_W-1:0];
  endfunction

  function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] c;
    c = (p < PULSE_LOW) ? PULSE_LOW : p;
    c = (c > PULSE_HIGH) ? PULSE_HIGH : c;
    return c[PULSE_W-1:0];
  endfunction

  logic v_r [5];

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < 5; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  logic signed [ANG_W-1:0] sa1_r, ea1_r, sa2_r, ea2_r;
  logic signed [DEG_W-1:0] sd3_r, ed3_r, sd4_r, ed4_r;
  logic signed [PW-1:0]    sp4_r, ep4_r;
  logic                    rch_r [4];
  result_t                 res_r;
  logic signed [PW-1:0]    sp_nxt, ep_nxt, cen, stp;

  // pulse = center + deg * step
  assign cen    = PW'({1'b0, cfg.center});
  assign stp    = PW'({1'b0, cfg.step});
  assign sp_nxt = cen + PW'(sd3_r) * stp;
  assign ep_nxt = cen + PW'(ed3_r) * stp;

  always_ff @(posedge clk) begin
    if (en) begin
      // shoulder = target angle minus elbow offset angle
      sa1_r    <= a_target - a_offset;
      ea1_r    <= a_elbow;
      rch_r[0] <= in_reach;
      // clamp to degree limits
      sa2_r    <= clamp_ang(sa1_r, cfg.s_min, cfg.s_max);
      ea2_r    <= clamp_ang(ea1_r, cfg.e_min, cfg.e_max);
      rch_r[1] <= rch_r[0];
      // whole degrees toward zero
      sd3_r    <= trunc_deg(sa2_r);
      ed3_r    <= trunc_deg(ea2_r);
      rch_r[2] <= rch_r[1];
      // pulse mapping
      sd4_r    <= sd3_r;
      ed4_r    <= ed3_r;
      sp4_r    <= sp_nxt;
      ep4_r    <= ep_nxt;
      rch_r[3] <= rch_r[2];
      // pulse clamp, unreachable targets read all zero
      if (rch_r[3]) begin
        res_r.reachable      <= 1'b1;
        res_r.shoulder_deg   <= sd4_r;
        res_r.elbow_angle    <= ed4_r;
        res_r.shoulder_pulse <= clamp_pulse(sp4_r);
        res_r.elbow_pulse    <= clamp_pulse(ep4_r);
      end else begin
        res_r <= '0;
      end
    end
  end

  assign out_v   = v_r[4];
  assign out_res = res_r;

endmodule

/* hdl/two_link_planar_ik_servo.sv */
// top level of the two-link planar inverse kinematics servo block
// depends on tlik_pkg, tlik_delay, tlik_isqrt, tlik_cordic and tlik_post
//
// Usage:
//   in_* carries one target transaction: x_pos and z_pos, signed, 8 fraction bits.
//   out_* carries one result per target: reachable in out_tuser, the clamped
//   shoulder and elbow angles in whole degrees and the two servo pulses in
//   out_tdata. Unreachable targets return reachable = 0 and all fields zero.
//   cfg_we/cfg_addr/cfg_wdata write the eight setup registers; write them only
//   while no transaction is in flight.
// Timing:
//   the datapath holds five front
//   stages of squares and compares, 25 square-root stages, a 6 + N stage
//   rotator pipeline (N = CORDIC_ITERATIONS), five output stages and the output register.
//   A new target can be taken every cycle while in_tready is high; the rate
//   is set by the fully pipelined datapath with one rotation or root step per stage.
// Reset and stall:
//   rst_n clears all valid bits and restores the register defaults.
//   When out_tready is low, the output register and one skid entry hold
//   results; once the skid entry fills, in_tready drops and the whole
//   pipeline freezes in place until the receiver takes a transaction.
module two_link_planar_ik_servo #(
  parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // x_pos [13:0], z_pos [27:14]
  input  logic [tlik_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // shoulder_deg [8:0], elbow_angle [17:9], shoulder_pulse [29:18],
  // elbow_pulse [41:30]
  output logic [tlik_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // reachable [0]
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [tlik_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [tlik_pkg::CFG_DW-1:0]         cfg_wdata
);
  import tlik_pkg::*;

  localparam int CORDIC_LAT = 1 + NORM_SHIFTS + CORDIC_ITERATIONS;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] z;
    logic signed [N_W-1:0] n;
    logic signed [W_W-1:0] w;
    logic                  reach;
  } side_t;

  // setup registers
  logic [LINK_W-1:0]       link1_length_r, link2_length_r;
  logic signed [DEG_W-1:0] s_min_r, s_max_r, e_min_r, e_max_r;
  logic [PULSE_W-1:0]      p_center_r;
  logic [STEP_W-1:0]       p_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_length_r <= RST_LINK1;
      link2_length_r <= RST_LINK2;
      s_min_r        <= RST_DEG_MIN;
      s_max_r        <= RST_DEG_MAX;
      e_min_r        <= RST_DEG_MIN;
      e_max_r        <= RST_DEG_MAX;
      p_center_r     <= RST_P_CENTER;
      p_step_r       <= RST_P_STEP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LINK1:    link1_length_r <= cfg_wdata[LINK_W-1:0];
        CFG_LINK2:    link2_length_r <= cfg_wdata[LINK_W-1:0];
        CFG_S_MIN:    s_min_r        <= cfg_wdata[DEG_W-1:0];
        CFG_S_MAX:    s_max_r        <= cfg_wdata[DEG_W-1:0];
        CFG_E_MIN:    e_min_r        <= cfg_wdata[DEG_W-1:0];
        CFG_E_MAX:    e_max_r        <= cfg_wdata[DEG_W-1:0];
        CFG_P_CENTER: p_center_r     <= cfg_wdata[PULSE_W-1:0];
        CFG_P_STEP:   p_step_r       <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: frozen only while the skid entry is occupied
  logic en;
  logic skid_v_r, out_v_r;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // front valid line
  logic fv_r [5];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) begin
        fv_r[k] <= 1'b0;
      end
    end else if (en) begin
      fv_r[0] <= in_tvalid;
      for (int k = 1; k < 5; k++) begin
        fv_r[k] <= fv_r[k-1];
      end
    end
  end

  // stage 1: squares and link products
  logic signed [X_W-1:0]      x_in, z_in;
  logic signed [2*X_W-1:0]    xx_full, zz_full;
  logic [LINK_W:0]            lsum;
  logic signed [LINK_W:0]     ldiff;
  logic [2*LINK_W+1:0]        sum2_full;
  logic signed [2*LINK_W+1:0] dif2_full;
  logic [2*LINK_W-1:0]        l11_full, l22_full, l12_full;

  assign x_in      = in_tdata[X_W-1:0];
  assign z_in      = in_tdata[2*X_W-1:X_W];
  assign xx_full   = x_in * x_in;
  assign zz_full   = z_in * z_in;
  assign lsum      = {1'b0, link1_length_r} + {1'b0, link2_length_r};
  assign ldiff     = $signed({1'b0, link1_length_r}) - $signed({1'b0, link2_length_r});
  assign sum2_full = lsum * lsum;
  assign dif2_full = ldiff * ldiff;
  assign l11_full  = link1_length_r * link1_length_r;
  assign l22_full  = link2_length_r * link2_length_r;
  assign l12_full  = link1_length_r * link2_length_r;

  logic signed [X_W-1:0] x1_r, z1_r, x2_r, z2_r, x3_r, z3_r, x4_r, z4_r, x5_r, z5_r;
  logic [XX_W-1:0]       xx1_r, zz1_r;
  logic [LSQ_W-1:0]      l11_r, l22_r, l12_r;
  logic [SUM2_W-1:0]     sum21_r, sum22_r;
  logic [DIF2_W-1:0]     dif21_r, dif22_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x_in;
      z1_r    <= z_in;
      xx1_r   <= xx_full[XX_W-1:0];
      zz1_r   <= zz_full[XX_W-1:0];
      l11_r   <= l11_full;
      l22_r   <= l22_full;
      l12_r   <= l12_full;
      sum21_r <= sum2_full;
      dif21_r <= dif2_full[DIF2_W-1:0];
    end
  end

  // stage 2: squared distance and link sums
  logic [D2_W-1:0]         d2_r;
  logic [LSQ_W:0]          lsq_r;
  logic signed [LSQ_W:0]   ldq_r;
  logic [P_W-1:0]          p2_r, p3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r    <= x1_r;
      z2_r    <= z1_r;
      d2_r    <= {1'b0, xx1_r} + {1'b0, zz1_r};
      lsq_r   <= {1'b0, l11_r} + {1'b0, l22_r};
      ldq_r   <= $signed({1'b0, l11_r}) - $signed({1'b0, l22_r});
      p2_r    <= {l12_r, 1'b0};
      sum22_r <= sum21_r;
      dif22_r <= dif21_r;
    end
  end

  // stage 3: cosine-law numerator, offset term and reach test
  logic signed [D2_W+1:0] n_full, w_full;
  logic signed [N_W-1:0]  n3_r, n4_r, n5_r;
  logic signed [W_W-1:0]  w3_r, w4_r, w5_r;
  logic                   r3_r, r4_r, r5_r;

  assign n_full = $signed({2'b00, d2_r}) - $signed((D2_W+2)'(lsq_r));
  assign w_full = $signed({2'b00, d2_r}) + (D2_W+2)'(ldq_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x3_r <= x2_r;
      z3_r <= z2_r;
      n3_r <= n_full[N_W-1:0];
      w3_r <= w_full[W_W-1:0];
      r3_r <= !((d2_r > D2_W'(sum22_r)) || (d2_r < D2_W'(dif22_r)));
      p3_r <= p2_r;
    end
  end

  // stage 4: squares for the radicand
  logic signed [2*N_W-1:0] nn_full;
  logic [2*N_W-1:0]        nn4_r;
  logic [RAD_W-1:0]        pp4_r, rad5_r;

  assign nn_full = n3_r * n3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x4_r  <= x3_r;
      z4_r  <= z3_r;
      n4_r  <= n3_r;
      w4_r  <= w3_r;
      r4_r  <= r3_r;
      nn4_r <= nn_full;
      pp4_r <= p3_r * p3_r;
    end
  end

  // stage 5: radicand, zero where n^2 reaches p^2
  always_ff @(posedge clk) begin
    if (en) begin
      x5_r   <= x4_r;
      z5_r   <= z4_r;
      n5_r   <= n4_r;
      w5_r   <= w4_r;
      r5_r   <= r4_r;
      rad5_r <= (nn4_r < (2*N_W)'(pp4_r)) ? (pp4_r - nn4_r[RAD_W-1:0]) : '0;
    end
  end

  // square root, side data delayed alongside
  logic              sq_v;
  logic [ROOT_W-1:0] root;
  side_t             side_in, side_q;

  assign side_in = '{x: x5_r, z: z5_r, n: n5_r, w: w5_r, reach: r5_r};

  tlik_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (fv_r[4]),
    .in_rad   (rad5_r),
    .out_v    (sq_v),
    .out_root (root)
  );

  tlik_delay #(.WIDTH($bits(side_t)), .DEPTH(ISQ_STEPS)) u_side_dly (
    .clk (clk),
    .en  (en),
    .d   (side_in),
    .q   (side_q)
  );

  // three angle rotators in parallel
  logic signed [VIN_W-1:0] s_v, n_v, w_v, x_v, z_v;
  logic                    v_ce, v_cw, v_cz, reach_c;
  logic signed [ANG_W-1:0] a_e, a_w, a_z;

  assign s_v = VIN_W'(root);
  assign n_v = VIN_W'(side_q.n);
  assign w_v = VIN_W'(side_q.w);
  assign x_v = VIN_W'(side_q.x);
  assign z_v = VIN_W'(side_q.z);

  tlik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_elbow (
    .clk (clk), .rst_n (rst_n), .en (en), .in_v (sq_v),
    .in_y (s_v), .in_x (n_v), .out_v (v_ce), .out_ang (a_e)
  );

  tlik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_offset (
    .clk (clk), .rst_n (rst_n), .en (en), .in_v (sq_v),
    .in_y (s_v), .in_x (w_v), .out_v (v_cw), .out_ang (a_w)
  );

  tlik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_target (
    .clk (clk), .rst_n (rst_n), .en (en), .in_v (sq_v),
    .in_y (z_v), .in_x (x_v), .out_v (v_cz), .out_ang (a_z)
  );

  tlik_delay #(.WIDTH(1), .DEPTH(CORDIC_LAT)) u_reach_dly (
    .clk (clk),
    .en  (en),
    .d   (side_q.reach),
    .q   (reach_c)
  );

  // clamp and pulse mapping
  post_cfg_t post_cfg;
  logic      post_v;
  result_t   post_res;

  assign post_cfg = '{s_min: s_min_r, s_max: s_max_r, e_min: e_min_r, e_max: e_max_r,
                      center: p_center_r, step: p_step_r};

  tlik_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_ce),
    .in_reach (reach_c),
    .a_target (a_z),
    .a_elbow  (a_e),
    .a_offset (a_w),
    .cfg      (post_cfg),
    .out_v    (post_v),
    .out_res  (post_res)
  );

  // output register with one skid entry
  result_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      priority if (skid_v_r) begin
        if (out_tready) skid_v_r <= 1'b0;
      end else if (post_v) begin
        if (out_v_r && !out_tready) skid_v_r <= 1'b1;
        else out_v_r <= 1'b1;
      end else begin
        if (out_tready) out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_v_r) begin
      if (out_tready) out_r <= skid_r;
    end else begin
      if (post_v) begin
        if (out_v_r && !out_tready) skid_r <= post_res;
        else out_r <= post_res;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.reachable;
  assign out_tdata  = {{(OUT_TDATA_W - 2*DEG_W - 2*PULSE_W){1'b0}},
                       out_r.elbow_pulse, out_r.shoulder_pulse,
                       out_r.elbow_angle, out_r.shoulder_deg};

  // the three rotators must stay in lockstep
  a_rot_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (v_ce == v_cw) && (v_cw == v_cz))
    else $error("rotator valid bits disagree");

  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry occupied with empty output register");

  // a frozen pipeline resumes only after the receiver takes a transaction
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_tready) |=> skid_v_r)
    else $error("skid entry dropped without a transaction");

  // unreachable results carry zeros, reachable ones carry legal pulses
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_r.reachable && (out_tdata == '0)) ||
                (out_r.reachable &&
                 (out_r.shoulder_pulse >= 12'd500) && (out_r.shoulder_pulse <= 12'd2500) &&
                 (out_r.elbow_pulse >= 12'd500) && (out_r.elbow_pulse <= 12'd2500)))
    else $error("result fields out of range");

endmodule
